[design/wgm_pkg.sv]
// ----------------------------------------------------------------------------
// Glob matcher package
// Register indexes, pattern constants, the link between cells and the
// ASCII case fold shared by the matcher and its cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = 6;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEN   = 3'd0,
		REG_WORD0 = 3'd1,
		REG_WORD1 = 3'd2,
		REG_WORD2 = 3'd3,
		REG_WORD3 = 3'd4,
		REG_WORD4 = 3'd5,
		REG_WORD5 = 3'd6,
		REG_FOLD  = 3'd7
	} cfg_reg_t;

	// Per-cycle controls that every cell sees.
	typedef struct packed {
		logic             recl;
		logic [LEN_W-1:0] len;
		logic [7:0]       ch;
		logic             fold;
	} cell_ctl_t;

	// Signals handed from one cell to the next.
	typedef struct packed {
		logic adv;
		logic carry;
		logic scarry;
	} link_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && (c inside {[CH_UP_A:CH_UP_Z]}))
			r = c + CASE_OFS;
		return r;
	endfunction

endpackage

[design/wgm_cell.sv]
// ----------------------------------------------------------------------------
// Glob matcher cell
// One pattern position: advances its live bit on a character and passes
// the star closure on to the next position.
// ----------------------------------------------------------------------------
module wgm_cell import wgm_pkg::*; #(
	parameter int IDX = 0
) (
	input  cell_ctl_t  ctl,
	input  logic [7:0] pat_byte,
	input  logic       live,
	input  link_t      link_i,
	output link_t      link_o,
	output logic       cl,
	output logic       scl,
	output logic       at_end
);

	logic [7:0] p;
	logic       star;
	logic       qmark;
	logic       active;
	logic       in_range;
	logic       base;
	logic       keep;

	always_comb begin
		p        = fold_char(pat_byte, ctl.fold);
		star     = (p == CH_STAR);
		qmark    = (p == CH_QMARK);
		active   = (ctl.len > LEN_W'(IDX));
		in_range = (ctl.len >= LEN_W'(IDX));
		at_end   = (ctl.len == LEN_W'(IDX));

		// A star keeps its own position alive; any other byte moves on when it matches.
		keep = live & active & star;
		link_o.adv = live & active & ~star & (qmark | (p == ctl.ch));

		// In a re-closure pass the stored bit is only trimmed to the length.
		base = ctl.recl ? (live & in_range) : (keep | link_i.adv);
		cl   = base | link_i.carry;
		link_o.carry = cl & star & active;

		// Start set: position zero plus the leading star run.
		scl = (IDX == 0) | link_i.scarry;
		link_o.scarry = scl & star & active;
	end

endmodule

[design/wildcard_glob_matcher.sv]
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Whole-string match of a text stream against a pattern with '*' and '?'.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while s_tready is high, set by the
//   star-closure chain that ripples through the row of cells combinationally.
// The verdict is registered and shows on m_tvalid in the cycle after the
//   transfer that carries tlast.
// Configuration writes hold tready low, and a re-closure step follows them with tready still low.
// Reset clears the configuration and output registers; the live set and the start set become pattern position zero.
module wildcard_glob_matcher import wgm_pkg::*; #(
	parameter int MAX_PATTERN = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // [7:0] text_byte
	input  logic [0:0]           s_tuser,    // [0] no_byte
	input  logic                 s_tlast,    // last_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,    // [0] matched, [7:1] zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	// Positions 0..MAX_PATTERN; the last one means the whole pattern is used.
	localparam int NUM_POS = MAX_PATTERN + 1;

	logic [LEN_W-1:0]  len_q;
	logic [WORD_W-1:0] word_q [NUM_WORDS];
	logic              fold_q;

	// Outside a re-closure, live_q is kept closed under the stars of the current pattern.
	// start_q is the closed start set, used to restart after tlast.
	// at_start_q says that no character has been taken since the last restart,
	// so a new pattern has to rebuild the live set from position zero alone.
	logic [NUM_POS-1:0] live_q;
	logic [NUM_POS-1:0] start_q;
	logic               at_start_q;
	logic               dirty_q;

	logic               out_valid_q;
	logic               out_match_q;

	logic [LEN_W-1:0]   n_eff;
	cell_ctl_t          ctl;
	link_t              link [NUM_POS+1];
	logic [NUM_POS-1:0] cl_vec;
	logic [NUM_POS-1:0] scl_vec;
	logic [NUM_POS-1:0] end_vec;
	logic               in_acc;
	logic               verdict;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			fold_q <= 1'b0;
			for (int w = 0; w < NUM_WORDS; w++)
				word_q[w] <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LEN:  len_q  <= cfg_data[LEN_W-1:0];
				REG_FOLD: fold_q <= cfg_data[0];
				default: begin
					if (cfg_index inside {[REG_WORD0:REG_WORD5]})
						word_q[3'(cfg_index - REG_WORD0)] <= cfg_data;
				end
			endcase
		end
	end

	// Lengths beyond the cell row are clamped to the full row.
	assign n_eff = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;

	// While dirty_q is set the cells re-close the stored set under the new
	// pattern instead of consuming a character. The stored set is only taken
	// over once the last write of a burst has landed.
	always_comb begin
		ctl.recl = dirty_q;
		ctl.len  = n_eff;
		ctl.ch   = fold_char(s_tdata, fold_q);
		ctl.fold = fold_q;
	end

	// ---------------------------------------------------------------------
	// Row of cells, one per pattern position
	// ---------------------------------------------------------------------
	assign link[0] = '0;

	for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
		logic [7:0] pat_byte;

		// The final position has no pattern byte; it is never active.
		if (i < MAX_PATTERN) begin : g_byte
			assign pat_byte = word_q[i / 8][(i % 8) * 8 +: 8];
		end else begin : g_none
			assign pat_byte = '0;
		end

		wgm_cell #(
			.IDX(i)
		) u_cell (
			.ctl      (ctl),
			.pat_byte (pat_byte),
			.live     (live_q[i]),
			.link_i   (link[i]),
			.link_o   (link[i+1]),
			.cl       (cl_vec[i]),
			.scl      (scl_vec[i]),
			.at_end   (end_vec[i])
		);
	end

	// ---------------------------------------------------------------------
	// Stream control
	// ---------------------------------------------------------------------
	// A transfer that ends a string needs room in the output register; all
	// other transfers go in regardless of the output side.
	assign s_tready = ~dirty_q & ~cfg_we & (~s_tlast | ~out_valid_q | m_tready);
	assign in_acc   = s_tvalid & s_tready;

	// An item with no byte reports on the set as it stands.
	assign verdict = s_tuser[0] ? |(live_q & end_vec) : |(cl_vec & end_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= NUM_POS'(1);
			start_q     <= NUM_POS'(1);
			at_start_q  <= 1'b1;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_match_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (dirty_q) begin
				dirty_q <= 1'b0;
				live_q  <= at_start_q ? scl_vec : cl_vec;
				start_q <= scl_vec;
			end else if (in_acc) begin
				if (s_tlast) begin
					live_q     <= start_q;
					at_start_q <= 1'b1;
				end else if (!s_tuser[0]) begin
					live_q     <= cl_vec;
					at_start_q <= 1'b0;
				end
			end

			if (in_acc && s_tlast)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (in_acc && s_tlast)
				out_match_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_match_q};

`ifndef SYNTHESIS
	// Exactly one position marks the end of the clamped pattern.
	a_end_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(end_vec))
		else $error("end position not one-hot");

	// No transfer is taken during a re-closure cycle.
	a_no_acc_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		dirty_q |-> !s_tready)
		else $error("transfer taken while re-closing");

	// Outside a re-closure the live set holds no position past the length.
	a_live_range: assert property (@(posedge clk) disable iff (!arst_n)
		!dirty_q |-> ((live_q & ~((end_vec << 1) - NUM_POS'(1))) == '0))
		else $error("live position beyond pattern length");

	// A verdict never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tlast) |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// After the end of a string the live set restarts from the start set.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tlast) |=> (live_q == $past(start_q)))
		else $error("live set not restarted");
`endif

endmodule
